// ===== rtl/cahc_pkg.sv =====
// Shared types, constants and helpers for the call arc hash counter.
package cahc_pkg;

  localparam int unsigned BUCKETS_DEF = 8192;
  localparam int unsigned POOL_ENTRIES_DEF = 4096;

  localparam logic [31:0] HASH_MUL = 32'h1f1f1f1f;
  localparam logic [31:0] COUNT_MAX = 32'hffffffff;

  localparam int unsigned SLOT_W = 14;
  localparam int unsigned NEXT_W = 12;
  localparam int unsigned USED_W = 13;
  localparam int unsigned WEIGHT_W = 16;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_MERGED      = 3'd0,
    ST_NEW_HEAD    = 3'd1,
    ST_NEW_CHAINED = 3'd2,
    ST_DROP_FULL   = 3'd3,
    ST_DROP_ZERO   = 3'd4,
    ST_READ        = 3'd5
  } status_t;

  // One stored arc.
  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] ret;
    logic [31:0] count;
  } arc_t;

  // Strobes from the sequencer to the table memories.
  typedef struct packed {
    logic head_rd;
    logic head_wr;
    logic pool_rd;
    logic pool_wr;
  } mem_cmd_t;

  function automatic logic [31:0] sat_add(input logic [31:0] count,
                                          input logic [WEIGHT_W-1:0] w);
    logic [32:0] sum;
    sum = {1'b0, count} + 33'(w);
    return sum[32] ? COUNT_MAX : sum[31:0];
  endfunction

endpackage

// ===== rtl/cahc_hash.sv =====
// Bucket hash: registered multiply, then a mask or a reciprocal remainder.
module cahc_hash #(
  parameter int unsigned BUCKETS = cahc_pkg::BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                pc,
  input  logic [31:0]                ret,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int unsigned HBW = $clog2(BUCKETS);
  localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  // Truncated reciprocal, so the quotient estimate falls short by at most one.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

  typedef enum logic [1:0] {H_IDLE, H_KEY, H_MUL, H_MOD} phase_t;

  phase_t         phase;
  logic [31:0]    prod;
  logic [31:0]    ret_q;
  logic [31:0]    key_q;
  logic [31:0]    quot;
  logic [31:0]    diff;
  logic [31:0]    key;
  logic [63:0]    key_recip;
  logic [31:0]    quot_b;
  logic [31:0]    reduced;

  assign key = prod ^ ret_q;
  assign key_recip = 64'(key) * 64'(RECIP);
  assign quot_b = quot * 32'(BUCKETS);
  assign reduced = (diff >= 32'(BUCKETS)) ? diff - 32'(BUCKETS) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= H_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        H_IDLE: begin
          if (start) begin
            prod <= pc * cahc_pkg::HASH_MUL;
            ret_q <= ret;
            phase <= H_KEY;
          end
        end
        H_KEY: begin
          if (IS_POW2) begin
            bucket <= key[HBW-1:0];
            done <= 1'b1;
            phase <= H_IDLE;
          end else begin
            key_q <= key;
            quot <= key_recip[63:32];
            phase <= H_MUL;
          end
        end
        H_MUL: begin
          // The remainder left here is below twice the bucket count.
          diff <= key_q - quot_b;
          phase <= H_MOD;
        end
        H_MOD: begin
          bucket <= reduced[HBW-1:0];
          done <= 1'b1;
          phase <= H_IDLE;
        end
        default: phase <= H_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cahc_tables.sv =====
// Head table and overflow pool memories, each with a registered read port.
module cahc_tables #(
  parameter int unsigned BUCKETS = cahc_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_ENTRIES = cahc_pkg::POOL_ENTRIES_DEF
) (
  input  logic                                       clk,
  input  cahc_pkg::mem_cmd_t                         cmd,
  input  logic [$clog2(BUCKETS)-1:0]                 head_addr,
  input  logic [97+$clog2(POOL_ENTRIES+1)-1:0]       head_wdata,
  output logic [97+$clog2(POOL_ENTRIES+1)-1:0]       head_rdata,
  input  logic [$clog2(POOL_ENTRIES)-1:0]            pool_addr,
  input  logic [96+$clog2(POOL_ENTRIES+1)-1:0]       pool_wdata,
  output logic [96+$clog2(POOL_ENTRIES+1)-1:0]       pool_rdata
);

  localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned HW = 97 + LW;
  localparam int unsigned PW = 96 + LW;

  logic [HW-1:0] head_mem [BUCKETS];
  logic [PW-1:0] pool_mem [POOL_ENTRIES];

  always_ff @(posedge clk) begin
    if (cmd.head_wr) begin
      head_mem[head_addr] <= head_wdata;
    end
    if (cmd.head_rd) begin
      head_rdata <= head_mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pool_wr) begin
      pool_mem[pool_addr] <= pool_wdata;
    end
    if (cmd.pool_rd) begin
      pool_rdata <= pool_mem[pool_addr];
    end
  end

endmodule

// ===== rtl/call_arc_hash_counter.sv =====
// Call arc hash counter: sequencer, result register and table instances.
//
// Usage: an item on the input channel is transferred when in_valid is high
// and in_stall is low. mode 0 records a (sample_pc, return_addr) arc with
// the given weight; mode 1 reads back one head or pool slot by slot_index.
// Each item gives exactly one result on the output channel, transferred when
// out_valid is high and out_stall is low.
// Items are handled one at a time. A dropped record, or a read of an unused
// pool slot, goes straight to the result register; any other read first
// reads its table slot. A record is hashed (with an extra remainder step
// when BUCKETS is not a power of two), then reads its head and merges into
// or fills it, or walks its pool chain entry by entry and, if none matches,
// writes a new pool entry and links it to the chain tail. The next item is
// taken in the cycle after its result is loaded. Table reads are registered.
// The result sits in an output register, so a stalled receiver holds the
// result steady while the next item is already being worked on; a second
// result waits inside until that register is free.
// After reset the head table is swept once to clear its valid bits, one
// bucket a cycle; in_stall stays high during the sweep.
module call_arc_hash_counter #(
  parameter int unsigned BUCKETS = cahc_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_ENTRIES = cahc_pkg::POOL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] sample_pc,
  input  logic [31:0] return_addr,
  input  logic [15:0] weight,
  input  logic [13:0] slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        entry_valid,
  output logic [31:0] entry_pc,
  output logic [31:0] entry_ret,
  output logic [31:0] entry_count,
  output logic        has_next,
  output logic [11:0] next_index,
  output logic [12:0] pool_used,
  output logic        table_full
);

  localparam int unsigned HBW = $clog2(BUCKETS);
  localparam int unsigned PBW = $clog2(POOL_ENTRIES);
  localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned HW = 97 + LW;
  localparam int unsigned PW = 96 + LW;
  localparam int unsigned UW = cahc_pkg::USED_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_POOL, S_ALLOC, S_LINK, S_RD, S_DONE
  } state_t;

  state_t             state;
  logic [HBW-1:0]     clr_addr;
  logic [LW-1:0]      pool_fill;
  logic               full_flag;
  logic [31:0]        k_pc;
  logic [31:0]        k_ret;
  logic [15:0]        k_w;
  logic [PBW-1:0]     cur;
  logic               prev_is_head;
  logic               rd_pool;
  cahc_pkg::status_t  res_status;
  logic               res_valid;
  cahc_pkg::arc_t     res_arc;
  logic [LW-1:0]      res_link;

  cahc_pkg::mem_cmd_t cmd;
  logic [HBW-1:0]     head_addr;
  logic [HW-1:0]      head_wdata;
  logic [HW-1:0]      head_rdata;
  logic [PBW-1:0]     pool_addr;
  logic [PW-1:0]      pool_wdata;
  logic [PW-1:0]      pool_rdata;

  logic               hash_start;
  logic               hash_done;
  logic [HBW-1:0]     bucket;

  logic               accept;
  logic               drop_full;
  logic [16:0]        slot_ext;
  logic               idx_is_head;
  logic [16:0]        pool_off;
  logic               pool_ok;
  logic               head_hv;
  cahc_pkg::arc_t     head_arc;
  logic [LW-1:0]      head_lnk;
  cahc_pkg::arc_t     pool_arc;
  logic [LW-1:0]      pool_lnk;
  logic               head_match;
  logic               pool_match;
  logic [31:0]        head_sum;
  logic [31:0]        pool_sum;
  logic [LW-1:0]      fill_inc;
  logic               out_free;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign drop_full = full_flag || (pool_fill >= LW'(POOL_ENTRIES));

  assign slot_ext = 17'(slot_index);
  assign idx_is_head = slot_ext < 17'(BUCKETS);
  assign pool_off = slot_ext - 17'(BUCKETS);
  assign pool_ok = !idx_is_head && (pool_off < 17'(pool_fill));

  assign head_hv = head_rdata[HW-1];
  assign head_arc = head_rdata[HW-2:LW];
  assign head_lnk = head_rdata[LW-1:0];
  assign pool_arc = pool_rdata[PW-1:LW];
  assign pool_lnk = pool_rdata[LW-1:0];
  assign head_match = (head_arc.pc == k_pc) && (head_arc.ret == k_ret);
  assign pool_match = (pool_arc.pc == k_pc) && (pool_arc.ret == k_ret);
  assign head_sum = cahc_pkg::sat_add(head_arc.count, k_w);
  assign pool_sum = cahc_pkg::sat_add(pool_arc.count, k_w);
  assign fill_inc = pool_fill + LW'(1);
  assign out_free = !out_valid || !out_stall;

  assign hash_start = accept && (mode == cahc_pkg::MODE_RECORD) && !drop_full &&
                      (sample_pc != 32'd0);

  cahc_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .pc     (sample_pc),
    .ret    (return_addr),
    .done   (hash_done),
    .bucket (bucket)
  );

  cahc_tables #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_tables (
    .clk        (clk),
    .cmd        (cmd),
    .head_addr  (head_addr),
    .head_wdata (head_wdata),
    .head_rdata (head_rdata),
    .pool_addr  (pool_addr),
    .pool_wdata (pool_wdata),
    .pool_rdata (pool_rdata)
  );

  // Memory addressing and write data for each step of the sequencer.
  always_comb begin
    cmd = '0;
    head_addr = bucket;
    head_wdata = '0;
    pool_addr = cur;
    pool_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.head_wr = 1'b1;
        head_addr = clr_addr;
      end
      S_IDLE: begin
        if (accept && (mode == cahc_pkg::MODE_READ)) begin
          if (idx_is_head) begin
            cmd.head_rd = 1'b1;
            head_addr = HBW'(slot_index);
          end else if (pool_ok) begin
            cmd.pool_rd = 1'b1;
            pool_addr = PBW'(pool_off);
          end
        end
      end
      S_HASH: begin
        cmd.head_rd = hash_done;
      end
      S_HEAD: begin
        if (!head_hv) begin
          cmd.head_wr = 1'b1;
          head_wdata = {1'b1, k_pc, k_ret, 32'(k_w), LW'(0)};
        end else if (head_match) begin
          cmd.head_wr = 1'b1;
          head_wdata = {1'b1, k_pc, k_ret, head_sum, head_lnk};
        end else if (head_lnk != '0) begin
          cmd.pool_rd = 1'b1;
          pool_addr = PBW'(head_lnk - LW'(1));
        end
      end
      S_POOL: begin
        if (pool_match) begin
          cmd.pool_wr = 1'b1;
          pool_wdata = {k_pc, k_ret, pool_sum, pool_lnk};
        end else if (pool_lnk != '0) begin
          cmd.pool_rd = 1'b1;
          pool_addr = PBW'(pool_lnk - LW'(1));
        end
      end
      S_ALLOC: begin
        cmd.pool_wr = 1'b1;
        pool_addr = PBW'(pool_fill);
        pool_wdata = {k_pc, k_ret, 32'(k_w), LW'(0)};
      end
      S_LINK: begin
        // The previous chain tail still sits in the memory read register.
        if (prev_is_head) begin
          cmd.head_wr = 1'b1;
          head_wdata = {1'b1, head_arc, fill_inc};
        end else begin
          cmd.pool_wr = 1'b1;
          pool_wdata = {pool_arc, fill_inc};
        end
      end
      S_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  function automatic logic [11:0] NEXT_W_CAST(input logic [LW-1:0] link);
    logic [LW-1:0] idx;
    idx = link - LW'(1);
    return 12'(idx);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      pool_fill <= '0;
      full_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + HBW'(1);
          if (clr_addr == HBW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            k_pc <= sample_pc;
            k_ret <= return_addr;
            k_w <= weight;
            res_valid <= 1'b0;
            res_arc <= '0;
            res_link <= '0;
            if (mode == cahc_pkg::MODE_READ) begin
              res_status <= cahc_pkg::ST_READ;
              rd_pool <= !idx_is_head;
              state <= (idx_is_head || pool_ok) ? S_RD : S_DONE;
            end else if (drop_full) begin
              full_flag <= 1'b1;
              res_status <= cahc_pkg::ST_DROP_FULL;
              state <= S_DONE;
            end else if (sample_pc == 32'd0) begin
              res_status <= cahc_pkg::ST_DROP_ZERO;
              state <= S_DONE;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          prev_is_head <= 1'b1;
          if (!head_hv) begin
            res_status <= cahc_pkg::ST_NEW_HEAD;
            res_valid <= 1'b1;
            res_arc <= '{pc: k_pc, ret: k_ret, count: 32'(k_w)};
            res_link <= '0;
            state <= S_DONE;
          end else if (head_match) begin
            res_status <= cahc_pkg::ST_MERGED;
            res_valid <= 1'b1;
            res_arc <= '{pc: k_pc, ret: k_ret, count: head_sum};
            res_link <= head_lnk;
            state <= S_DONE;
          end else if (head_lnk != '0) begin
            cur <= PBW'(head_lnk - LW'(1));
            state <= S_POOL;
          end else begin
            state <= S_ALLOC;
          end
        end
        S_POOL: begin
          prev_is_head <= 1'b0;
          if (pool_match) begin
            res_status <= cahc_pkg::ST_MERGED;
            res_valid <= 1'b1;
            res_arc <= '{pc: k_pc, ret: k_ret, count: pool_sum};
            res_link <= pool_lnk;
            state <= S_DONE;
          end else if (pool_lnk != '0) begin
            cur <= PBW'(pool_lnk - LW'(1));
          end else begin
            state <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          state <= S_LINK;
        end
        S_LINK: begin
          pool_fill <= fill_inc;
          full_flag <= (fill_inc >= LW'(POOL_ENTRIES));
          res_status <= cahc_pkg::ST_NEW_CHAINED;
          res_valid <= 1'b1;
          res_arc <= '{pc: k_pc, ret: k_ret, count: 32'(k_w)};
          res_link <= '0;
          state <= S_DONE;
        end
        S_RD: begin
          if (rd_pool) begin
            res_valid <= 1'b1;
            res_arc <= pool_arc;
            res_link <= pool_lnk;
          end else if (head_hv) begin
            res_valid <= 1'b1;
            res_arc <= head_arc;
            res_link <= head_lnk;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status <= res_status;
            entry_valid <= res_valid;
            entry_pc <= res_arc.pc;
            entry_ret <= res_arc.ret;
            entry_count <= res_arc.count;
            has_next <= (res_link != '0);
            next_index <= (res_link != '0) ? NEXT_W_CAST(res_link) : '0;
            pool_used <= UW'(pool_fill);
            table_full <= full_flag;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_full_means_exhausted: assert property (@(posedge clk) disable iff (rst)
    full_flag |-> (pool_fill == LW'(POOL_ENTRIES)))
    else $error("full flag set while pool entries remain");

  a_fill_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (pool_fill != $past(pool_fill))) |->
      (pool_fill == $past(pool_fill) + LW'(1)))
    else $error("pool fill count moved by other than one");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!cmd.head_wr && !cmd.pool_wr))
    else $error("table write while no item is in progress");

  a_hash_only_when_waited: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == S_HASH))
    else $error("hash result arrived outside the hash step");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the call arc hash counter: stimulus, prediction and result checks.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned BUCKETS = cahc_pkg::BUCKETS_DEF;
  localparam int unsigned POOL = cahc_pkg::POOL_ENTRIES_DEF;
  localparam logic [13:0] SLOT_TOP = 14'(BUCKETS + POOL - 1);
  localparam int unsigned WATCHDOG_LIMIT = 50000;

  typedef struct packed {
    cahc_pkg::status_t status;
    logic        valid;
    logic [31:0] pc;
    logic [31:0] ret;
    logic [31:0] count;
    logic        has_next;
    logic [11:0] link_idx;
    logic [12:0] used;
    logic        full;
  } arc_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [31:0] sample_pc;
  logic [31:0] return_addr;
  logic [15:0] weight;
  logic [13:0] slot_index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic        entry_valid;
  logic [31:0] entry_pc;
  logic [31:0] entry_ret;
  logic [31:0] entry_count;
  logic        has_next;
  logic [11:0] next_index;
  logic [12:0] pool_used;
  logic        table_full;

  // Shadow copy of the arc table, updated as each item is transferred in.
  bit          hd_used [BUCKETS];
  logic [31:0] hd_pc   [BUCKETS];
  logic [31:0] hd_ret  [BUCKETS];
  logic [31:0] hd_cnt  [BUCKETS];
  logic [12:0] hd_link [BUCKETS];
  logic [31:0] pl_pc   [POOL];
  logic [31:0] pl_ret  [POOL];
  logic [31:0] pl_cnt  [POOL];
  logic [12:0] pl_link [POOL];
  int unsigned pl_fill;
  bit          pool_exhausted;

  arc_result_t pending_results[$];
  logic [31:0] seen_pc[$];
  logic [31:0] seen_ret[$];

  int          mismatches;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned sink_hold;
  int unsigned quiet_cycles;

  call_arc_hash_counter #(
    .BUCKETS(BUCKETS),
    .POOL_ENTRIES(POOL)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .sample_pc(sample_pc),
    .return_addr(return_addr),
    .weight(weight),
    .slot_index(slot_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .entry_valid(entry_valid),
    .entry_pc(entry_pc),
    .entry_ret(entry_ret),
    .entry_count(entry_count),
    .has_next(has_next),
    .next_index(next_index),
    .pool_used(pool_used),
    .table_full(table_full)
  );

  function automatic int unsigned arc_bucket(input logic [31:0] pc, input logic [31:0] ret);
    logic [31:0] prod;
    prod = pc * cahc_pkg::HASH_MUL;
    return (prod ^ ret) % BUCKETS;
  endfunction

  // Picks a return address, random in its upper part, that hashes with pc into bucket.
  function automatic logic [31:0] aim_ret(input logic [31:0] pc, input int unsigned bucket);
    logic [31:0] prod;
    logic [31:0] mix;
    prod = pc * cahc_pkg::HASH_MUL;
    mix = $urandom_range(32'hFFFE_0000);
    mix = mix - (mix % BUCKETS) + bucket;
    return prod ^ mix;
  endfunction

  function automatic logic [15:0] pick_weight();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] grown_count(input logic [31:0] cnt, input logic [15:0] w);
    logic [32:0] sum;
    sum = {1'b0, cnt} + {17'b0, w};
    return sum[32] ? cahc_pkg::COUNT_MAX : sum[31:0];
  endfunction

  function automatic arc_result_t shown(input cahc_pkg::status_t st, input logic [31:0] pc,
                                        input logic [31:0] ret, input logic [31:0] cnt,
                                        input logic [12:0] link);
    arc_result_t r;
    r = '0;
    r.status = st;
    r.valid = 1'b1;
    r.pc = pc;
    r.ret = ret;
    r.count = cnt;
    r.has_next = (link != 13'd0);
    r.link_idx = (link != 13'd0) ? 12'(link - 13'd1) : 12'd0;
    return r;
  endfunction

  // Applies one item to the shadow table and returns the result it should give.
  function automatic arc_result_t tally_arc(input logic m, input logic [31:0] pc,
                                            input logic [31:0] ret, input logic [15:0] w,
                                            input logic [13:0] idx);
    arc_result_t r;
    int unsigned h;
    int unsigned p;
    int unsigned prev;
    int unsigned steps;
    int unsigned slot;
    logic [12:0] link;
    bit at_head;
    bit found;
    r = '0;
    prev = 0;
    if (m == cahc_pkg::MODE_READ) begin
      r.status = cahc_pkg::ST_READ;
      if (idx < BUCKETS) begin
        if (hd_used[idx])
          r = shown(cahc_pkg::ST_READ, hd_pc[idx], hd_ret[idx], hd_cnt[idx], hd_link[idx]);
      end else begin
        slot = idx - BUCKETS;
        if (slot < pl_fill && slot < POOL)
          r = shown(cahc_pkg::ST_READ, pl_pc[slot], pl_ret[slot], pl_cnt[slot],
                    pl_link[slot]);
      end
    end else if (pool_exhausted || pl_fill >= POOL) begin
      // Once the pool runs out, every record is dropped, zero pc included.
      pool_exhausted = 1'b1;
      r.status = cahc_pkg::ST_DROP_FULL;
    end else if (pc == 32'd0) begin
      r.status = cahc_pkg::ST_DROP_ZERO;
    end else begin
      h = arc_bucket(pc, ret);
      if (!hd_used[h]) begin
        hd_used[h] = 1'b1;
        hd_pc[h] = pc;
        hd_ret[h] = ret;
        hd_cnt[h] = {16'd0, w};
        hd_link[h] = 13'd0;
        r = shown(cahc_pkg::ST_NEW_HEAD, pc, ret, {16'd0, w}, 13'd0);
      end else if (hd_pc[h] == pc && hd_ret[h] == ret) begin
        hd_cnt[h] = grown_count(hd_cnt[h], w);
        r = shown(cahc_pkg::ST_MERGED, pc, ret, hd_cnt[h], hd_link[h]);
      end else begin
        link = hd_link[h];
        at_head = 1'b1;
        found = 1'b0;
        steps = 0;
        while (link != 13'd0 && !found && steps < POOL) begin
          p = link - 1;
          if (pl_pc[p] == pc && pl_ret[p] == ret) begin
            pl_cnt[p] = grown_count(pl_cnt[p], w);
            r = shown(cahc_pkg::ST_MERGED, pc, ret, pl_cnt[p], pl_link[p]);
            found = 1'b1;
          end else begin
            prev = p;
            at_head = 1'b0;
            link = pl_link[p];
            steps++;
          end
        end
        if (!found) begin
          p = pl_fill;
          pl_pc[p] = pc;
          pl_ret[p] = ret;
          pl_cnt[p] = {16'd0, w};
          pl_link[p] = 13'd0;
          if (at_head) hd_link[h] = 13'(p + 1);
          else pl_link[prev] = 13'(p + 1);
          pl_fill++;
          if (pl_fill >= POOL) pool_exhausted = 1'b1;
          r = shown(cahc_pkg::ST_NEW_CHAINED, pc, ret, {16'd0, w}, 13'd0);
        end
      end
    end
    r.used = 13'(pl_fill);
    r.full = pool_exhausted;
    return r;
  endfunction

  task automatic send_item(input logic m, input logic [31:0] pc, input logic [31:0] ret,
                           input logic [15:0] w, input logic [13:0] idx);
    arc_result_t want;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    sample_pc <= pc;
    return_addr <= ret;
    weight <= w;
    slot_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    want = tally_arc(m, pc, ret, w, idx);
    pending_results.push_back(want);
    if (want.status == cahc_pkg::ST_NEW_HEAD || want.status == cahc_pkg::ST_NEW_CHAINED) begin
      seen_pc.push_back(pc);
      seen_ret.push_back(ret);
    end
  endtask

  task automatic send_record(input logic [31:0] pc, input logic [31:0] ret,
                             input logic [15:0] w);
    send_item(cahc_pkg::MODE_RECORD, pc, ret, w, 14'($urandom()));
  endtask

  task automatic send_read(input logic [13:0] idx);
    send_item(cahc_pkg::MODE_READ, $urandom(), $urandom(), 16'($urandom()), idx);
  endtask

  task automatic test_directed_cases;
    logic [31:0] ret_a;
    logic [31:0] ret_b;
    logic [31:0] ret_c;
    send_read(14'd0);
    send_read(14'(BUCKETS));
    send_read(14'h3FFF);
    send_record(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    // Three arcs in the top bucket: a head and a chain of two pool entries.
    ret_a = aim_ret(32'hFFFF_FFFF, BUCKETS - 1);
    ret_b = aim_ret(32'h0000_0001, BUCKETS - 1);
    ret_c = aim_ret(32'h8000_0000, BUCKETS - 1);
    send_record(32'hFFFF_FFFF, ret_a, 16'h0000);
    send_record(32'hFFFF_FFFF, ret_a, 16'hFFFF);
    send_record(32'h0000_0001, ret_b, 16'h0001);
    send_record(32'h8000_0000, ret_c, 16'h8000);
    send_record(32'h0000_0001, ret_b, 16'hFFFF);
    send_record(32'h8000_0000, ret_c, 16'h7FFF);
    send_record(32'hFFFF_FFFF, ret_a, 16'h0001);
    send_read(14'(BUCKETS - 1));
    send_read(14'(BUCKETS));
    send_read(14'(BUCKETS + 1));
    send_read(14'(BUCKETS + 2));
    send_read(SLOT_TOP);
    send_record(32'hFFFF_FFFF, 32'h0000_0000, 16'h1234);
    send_record(32'h0000_0001, 32'hFFFF_FFFF, 16'h0000);
    send_record(32'h1234_5678, aim_ret(32'h1234_5678, 0), 16'h00FF);
    send_read(14'd0);
  endtask

  task automatic test_random_traffic(input int unsigned items);
    int unsigned hot [8];
    int unsigned pick;
    int unsigned k;
    logic [31:0] pc;
    logic [13:0] idx;
    foreach (hot[i]) hot[i] = $urandom_range(BUCKETS - 1);
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // New arcs crowd a few buckets so that chains grow.
        pc = $urandom();
        send_record(pc, aim_ret(pc, hot[$urandom_range(7)]), pick_weight());
      end else if (pick < 70 && seen_pc.size() > 0) begin
        k = $urandom_range(seen_pc.size() - 1);
        send_record(seen_pc[k], seen_ret[k], pick_weight());
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0: idx = 14'(hot[$urandom_range(7)]);
          1: idx = 14'(BUCKETS + $urandom_range(pl_fill));
          default: idx = 14'($urandom_range(SLOT_TOP));
        endcase
        send_read(idx);
      end else if (pick < 90) begin
        send_record(32'd0, $urandom(), pick_weight());
      end else begin
        send_record($urandom(), $urandom(), pick_weight());
      end
    end
  endtask

  // The receiver holds off while items keep coming, so the block backs up.
  task automatic test_stall_backlog;
    logic [31:0] pc;
    sink_hold = 400;
    repeat (16) begin
      pc = $urandom();
      send_record(pc, aim_ret(pc, $urandom_range(BUCKETS - 1)), pick_weight());
    end
  endtask

  task automatic test_heavy_merges;
    int unsigned b;
    logic [31:0] ret;
    b = 0;
    while (hd_used[b]) b++;
    ret = aim_ret(32'h00C0_FFEE, b);
    // Full-weight merges carry the count well past the width of one weight.
    repeat (16) send_record(32'h00C0_FFEE, ret, 16'hFFFF);
    send_read(14'(b));
  endtask

  task automatic test_chain_growth;
    int unsigned n;
    logic [31:0] pc;
    n = 0;
    repeat (40) begin
      pc = $urandom();
      if (pc == 32'd0) pc = 32'd1;
      send_record(pc, aim_ret(pc, BUCKETS / 2 + n % 4), pick_weight());
      n++;
    end
    send_record(32'd0, $urandom(), 16'h0001);
    send_record(seen_pc[0], seen_ret[0], 16'h0001);
    send_read(SLOT_TOP);
    send_read(14'(BUCKETS));
    send_read(14'(arc_bucket(seen_pc[0], seen_ret[0])));
    repeat (8) begin
      pc = $urandom();
      send_record(pc, $urandom(), pick_weight());
      send_read(14'($urandom_range(SLOT_TOP)));
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, what, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    sink_hold = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_stall <= 1'b1;
        sink_hold = sink_hold - 1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    arc_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d pc 0x%08h", $time, status, entry_pc);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("entry_valid", 32'(want.valid), 32'(entry_valid));
        check_field("entry_pc", want.pc, entry_pc);
        check_field("entry_ret", want.ret, entry_ret);
        check_field("entry_count", want.count, entry_count);
        check_field("has_next", 32'(want.has_next), 32'(has_next));
        check_field("next_index", 32'(want.link_idx), 32'(next_index));
        check_field("pool_used", 32'(want.used), 32'(pool_used));
        check_field("table_full", 32'(want.full), 32'(table_full));
      end
    end
  end

  // Ends the run if neither channel has made a transfer for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = cahc_pkg::MODE_RECORD;
    sample_pc = '0;
    return_addr = '0;
    weight = '0;
    slot_index = '0;
    mismatches = 0;
    pl_fill = 0;
    pool_exhausted = 1'b0;
    src_idle_pct = 6;
    sink_stall_pct = 72;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(200);
    test_stall_backlog();
    src_idle_pct = 72;
    sink_stall_pct = 6;
    test_random_traffic(200);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    test_heavy_merges();
    test_chain_growth();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== call_arc_hash_counter.f =====
rtl/cahc_pkg.sv
rtl/cahc_hash.sv
rtl/cahc_tables.sv
rtl/call_arc_hash_counter.sv
verif/tb.sv
